// ===== src/mts_pkg.sv =====
// Package of shared types, constants and codes for the min-tracking stack.
`default_nettype none
package mts_pkg;

    localparam int VALUE_WIDTH   = 32;
    localparam int DEPTH_DEFAULT = 256;
    localparam int COUNT_WIDTH   = 9;

    typedef enum logic
    {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } cmd_t;

    typedef enum logic [1:0]
    {
        ERR_NONE  = 2'd0,
        ERR_EMPTY = 2'd1,
        ERR_FULL  = 2'd2
    } error_t;

    typedef struct packed
    {
        cmd_t                           cmd;
        logic signed [VALUE_WIDTH-1:0]  push_value;
    } in_item_t;

    typedef struct packed
    {
        logic signed [VALUE_WIDTH-1:0]  popped_value;
        logic signed [VALUE_WIDTH-1:0]  top_value;
        logic signed [VALUE_WIDTH-1:0]  min_value;
        logic [COUNT_WIDTH-1:0]         entry_count;
        logic                           is_empty;
        error_t                         error_code;
    } out_item_t;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_EXEC,
        ST_LOAD,
        ST_REPLY
    } state_t;

    typedef struct packed
    {
        logic accept;
        logic exec;
        logic load_top;
    } ctl_t;

    typedef struct packed
    {
        logic is_pop;
        logic is_empty;
    } sts_t;

endpackage
`default_nettype wire

// ===== src/mts_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== src/mts_ctrl.sv =====
// Controller state machine that sequences one stack operation at a time.
`default_nettype none
module mts_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire mts_pkg::sts_t sts,
    output mts_pkg::ctl_t      ctl,
    output logic               busy,
    output logic               done
);

    mts_pkg::state_t state_reg;
    mts_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mts_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl          = '0;
        busy         = 1'b1;
        done         = 1'b0;
        unique case (state_reg)
            mts_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    ctl.accept = 1'b1;
                    state_next = mts_pkg::ST_EXEC;
                end
            end
            mts_pkg::ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.is_pop && !sts.is_empty)
                begin
                    state_next = mts_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = mts_pkg::ST_REPLY;
                end
            end
            mts_pkg::ST_LOAD:
            begin
                ctl.load_top = 1'b1;
                state_next   = mts_pkg::ST_REPLY;
            end
            mts_pkg::ST_REPLY:
            begin
                done       = 1'b1;
                state_next = mts_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

// ===== src/mts_datapath.sv =====
// Datapath with the value and minima stacks, their pointers and cached tops.
`default_nettype none
module mts_datapath #(
    parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mts_pkg::ctl_t     ctl,
    input  wire mts_pkg::in_item_t item,
    output mts_pkg::sts_t          sts,
    output mts_pkg::out_item_t     result
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int VW = mts_pkg::VALUE_WIDTH;

    mts_pkg::in_item_t  item_reg;
    logic [CW-1:0]      count_reg;
    logic [CW-1:0]      mcount_reg;
    logic [VW-1:0]      top_reg;
    logic [VW-1:0]      min_reg;
    logic [VW-1:0]      popped_reg;
    mts_pkg::error_t    err_reg;
    logic               minpop_reg;

    logic [CW-1:0]      count_m2;
    logic [CW-1:0]      mcount_m2;
    logic               full;
    logic               min_push;
    logic               v_we;
    logic               m_we;
    logic [VW-1:0]      v_rdata;
    logic [VW-1:0]      m_rdata;
    logic [CW+mts_pkg::COUNT_WIDTH-1:0] count_ext;

    assign count_m2  = count_reg - CW'(2);
    assign mcount_m2 = mcount_reg - CW'(2);
    assign full      = (count_reg >= CW'(DEPTH));
    assign min_push  = (mcount_reg == '0) || ($signed(min_reg) >= item_reg.push_value);
    assign v_we      = ctl.exec && (item_reg.cmd == mts_pkg::CMD_PUSH) && !full;
    assign m_we      = v_we && min_push;

    assign sts.is_pop   = (item_reg.cmd == mts_pkg::CMD_POP);
    assign sts.is_empty = (count_reg == '0);

    mts_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item_reg.push_value),
        .raddr (count_m2[AW-1:0]),
        .rdata (v_rdata)
    );

    mts_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_minima_ram (
        .clk   (clk),
        .we    (m_we),
        .waddr (mcount_reg[AW-1:0]),
        .wdata (item_reg.push_value),
        .raddr (mcount_m2[AW-1:0]),
        .rdata (m_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            mcount_reg <= '0;
        end
        else if (ctl.exec)
        begin
            if (item_reg.cmd == mts_pkg::CMD_PUSH)
            begin
                if (!full)
                begin
                    count_reg <= count_reg + 1'b1;
                    if (min_push)
                    begin
                        mcount_reg <= mcount_reg + 1'b1;
                    end
                end
            end
            else if (count_reg != '0)
            begin
                count_reg <= count_reg - 1'b1;
                if (min_reg == top_reg)
                begin
                    mcount_reg <= mcount_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            item_reg <= item;
        end
        if (ctl.exec)
        begin
            popped_reg <= '0;
            err_reg    <= mts_pkg::ERR_NONE;
            minpop_reg <= 1'b0;
            if (item_reg.cmd == mts_pkg::CMD_PUSH)
            begin
                if (full)
                begin
                    err_reg <= mts_pkg::ERR_FULL;
                end
                else
                begin
                    top_reg <= item_reg.push_value;
                    if (min_push)
                    begin
                        min_reg <= item_reg.push_value;
                    end
                end
            end
            else if (count_reg == '0)
            begin
                err_reg <= mts_pkg::ERR_EMPTY;
            end
            else
            begin
                popped_reg <= top_reg;
                minpop_reg <= (min_reg == top_reg);
            end
        end
        if (ctl.load_top)
        begin
            top_reg <= v_rdata;
            if (minpop_reg)
            begin
                min_reg <= m_rdata;
            end
        end
    end

    assign count_ext = (CW + mts_pkg::COUNT_WIDTH)'(count_reg);

    always_comb
    begin
        result.popped_value = popped_reg;
        result.top_value    = sts.is_empty ? '0 : top_reg;
        result.min_value    = sts.is_empty ? '0 : min_reg;
        result.entry_count  = count_ext[mts_pkg::COUNT_WIDTH-1:0];
        result.is_empty     = sts.is_empty;
        result.error_code   = err_reg;
    end

endmodule
`default_nettype wire

// ===== src/min_tracking_stack_unit.sv =====
// Top level of the min-tracking stack: controller and datapath joined.
//
//   Channel   Ports                 Transfer
//   input     start, busy, item     rising edge with start high and busy low
//   result    done, result          rising edge ending the cycle with done high
//
// A push or a failed operation is taken at the edge that ends an idle cycle, runs
// the execute state and is answered in the reply state, at whose end the result is
// taken. A successful pop adds a load state between them, since the new tops come
// from the registered read data of the synchronous stack RAMs after the pointers
// move. The controller then returns to idle, so no new item is taken before the
// last result. Reset clears the controller and both stack pointers; the RAMs need no
// clearing. The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
module min_tracking_stack_unit #(
    parameter int DEPTH = mts_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire mts_pkg::in_item_t item,
    output logic                   busy,
    output logic                   done,
    output mts_pkg::out_item_t     result
);

    mts_pkg::ctl_t ctl;
    mts_pkg::sts_t sts;

    mts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    mts_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .item   (item),
        .sts    (sts),
        .result (result)
    );

endmodule
`default_nettype wire
